/* src/bru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bru_pkg
// Shared types and encoding constants for the AArch64 branch execute unit.
// ----------------------------------------------------------------------------
package bru_pkg;

  // Completion status of one executed instruction.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SVC    = 3'd1,
    ST_BRK    = 3'd2,
    ST_UNIMPL = 3'd3,
    ST_SYSTEM = 3'd4
  } status_t;

  // Instruction class after the top-level opcode match.
  typedef enum logic [2:0] {
    CL_B,
    CL_BCOND,
    CL_CMPBR,
    CL_TSTBR,
    CL_EXC,
    CL_BRREG,
    CL_SYS,
    CL_OTHER
  } insn_class_t;

  // Opcode masks and match values.
  localparam logic [31:0] MASK_B      = 32'h7C00_0000;
  localparam logic [31:0] MATCH_B     = 32'h1400_0000;
  localparam logic [31:0] MASK_BCOND  = 32'hFF00_0010;
  localparam logic [31:0] MATCH_BCOND = 32'h5400_0000;
  localparam logic [31:0] MASK_CTBR   = 32'h7E00_0000;
  localparam logic [31:0] MATCH_CMPBR = 32'h3400_0000;
  localparam logic [31:0] MATCH_TSTBR = 32'h3600_0000;
  localparam logic [31:0] MASK_EXC    = 32'hFF00_0000;
  localparam logic [31:0] MATCH_EXC   = 32'hD400_0000;
  localparam logic [31:0] MASK_BRREG  = 32'hFE00_0000;
  localparam logic [31:0] MATCH_BRREG = 32'hD600_0000;
  localparam logic [31:0] MASK_SYS    = 32'hFFC0_0000;
  localparam logic [31:0] MATCH_SYS   = 32'hD500_0000;

  // Exception-generation sub-opcodes.
  localparam logic [2:0] EXC_OPC_SVC = 3'd0;
  localparam logic [1:0] EXC_LL_SVC  = 2'd1;
  localparam logic [2:0] EXC_OPC_BRK = 3'd1;
  localparam logic [1:0] EXC_LL_BRK  = 2'd0;

  // Register branch sub-opcodes.
  localparam logic [3:0] BR_OPC_BR  = 4'd0;
  localparam logic [3:0] BR_OPC_BLR = 4'd1;
  localparam logic [3:0] BR_OPC_RET = 4'd2;

  // Condition code that is "always" without inversion.
  localparam logic [3:0] COND_NV = 4'hF;

  // Result of one executed instruction.
  typedef struct packed {
    logic [63:0] next_pc;
    logic        link_write;
    logic [63:0] link_value;
    status_t     status;
  } exec_result_t;

endpackage

/* src/bru_cond_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bru_cond_check
// Evaluates an AArch64 condition code against the NZCV flags.
// ----------------------------------------------------------------------------
module bru_cond_check (
  input  logic [3:0] cond,
  input  logic [3:0] nzcv,
  output logic       holds
);
  import bru_pkg::*;

  logic flag_n, flag_z, flag_c, flag_v;
  logic base;

  assign flag_n = nzcv[3];
  assign flag_z = nzcv[2];
  assign flag_c = nzcv[1];
  assign flag_v = nzcv[0];

  // Base test selected by the upper three condition bits.
  always_comb begin
    unique case (cond[3:1])
      3'd0:    base = flag_z;
      3'd1:    base = flag_c;
      3'd2:    base = flag_n;
      3'd3:    base = flag_v;
      3'd4:    base = flag_c & ~flag_z;
      3'd5:    base = (flag_n == flag_v);
      3'd6:    base = (flag_n == flag_v) & ~flag_z;
      default: base = 1'b1;
    endcase
  end

  // The low bit inverts the test, except for the second always-taken code.
  assign holds = (cond[0] && (cond != COND_NV)) ? ~base : base;

endmodule

/* src/bru_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bru_exec
// Decodes one branch-class instruction and computes next pc, link and status.
// ----------------------------------------------------------------------------
module bru_exec (
  input  logic [31:0]           insn,
  input  logic [63:0]           pc,
  input  logic [3:0]            nzcv,
  input  logic [63:0]           rv,
  output bru_pkg::exec_result_t result
);
  import bru_pkg::*;

  insn_class_t cls;
  logic [63:0] off_imm26, off_imm19, off_imm14;
  logic [63:0] offset;
  logic [63:0] target;
  logic [63:0] seq_pc;
  logic [63:0] test_val;
  logic [5:0]  bit_pos;
  logic        cond_ok;
  logic        taken;
  logic        link;
  logic [2:0]  exc_opc;
  logic [1:0]  exc_ll;
  logic [3:0]  br_opc;

  // Top-level opcode match, in priority order.
  always_comb begin
    priority if ((insn & MASK_B) == MATCH_B)          cls = CL_B;
    else if ((insn & MASK_BCOND) == MATCH_BCOND)      cls = CL_BCOND;
    else if ((insn & MASK_CTBR) == MATCH_CMPBR)       cls = CL_CMPBR;
    else if ((insn & MASK_CTBR) == MATCH_TSTBR)       cls = CL_TSTBR;
    else if ((insn & MASK_EXC) == MATCH_EXC)          cls = CL_EXC;
    else if ((insn & MASK_BRREG) == MATCH_BRREG)      cls = CL_BRREG;
    else if ((insn & MASK_SYS) == MATCH_SYS)          cls = CL_SYS;
    else                                              cls = CL_OTHER;
  end

  // Sign-extended, word-scaled branch offsets.
  assign off_imm26 = {{36{insn[25]}}, insn[25:0], 2'b00};
  assign off_imm19 = {{43{insn[23]}}, insn[23:5], 2'b00};
  assign off_imm14 = {{48{insn[18]}}, insn[18:5], 2'b00};

  // One shared target adder plus the sequential adder.
  always_comb begin
    unique case (cls)
      CL_B:     offset = off_imm26;
      CL_TSTBR: offset = off_imm14;
      default:  offset = off_imm19;
    endcase
  end

  assign target = pc + offset;
  assign seq_pc = pc + 64'd4;

  bru_cond_check u_cond (
    .cond  (insn[3:0]),
    .nzcv  (nzcv),
    .holds (cond_ok)
  );

  // Compare branch tests the low word only in its 32-bit form.
  assign test_val = insn[31] ? rv : {32'd0, rv[31:0]};
  assign bit_pos  = {insn[31], insn[23:19]};

  always_comb begin
    unique case (cls)
      CL_BCOND: taken = cond_ok;
      CL_CMPBR: taken = insn[24] ? (test_val != 64'd0) : (test_val == 64'd0);
      CL_TSTBR: taken = insn[24] ? rv[bit_pos] : ~rv[bit_pos];
      default:  taken = 1'b0;
    endcase
  end

  assign exc_opc = insn[23:21];
  assign exc_ll  = insn[1:0];
  assign br_opc  = insn[24:21];

  // Next pc, link and status per class.
  always_comb begin
    result.next_pc = pc;
    result.status  = ST_OK;
    link           = 1'b0;
    unique case (cls)
      CL_B: begin
        result.next_pc = target;
        link           = insn[31];
      end
      CL_BCOND, CL_CMPBR, CL_TSTBR: begin
        result.next_pc = taken ? target : seq_pc;
      end
      CL_EXC: begin
        if (exc_opc == EXC_OPC_SVC && exc_ll == EXC_LL_SVC) begin
          result.next_pc = seq_pc;
          result.status  = ST_SVC;
        end else if (exc_opc == EXC_OPC_BRK && exc_ll == EXC_LL_BRK) begin
          result.status = ST_BRK;
        end else begin
          result.status = ST_UNIMPL;
        end
      end
      CL_BRREG: begin
        if (br_opc == BR_OPC_BR || br_opc == BR_OPC_RET) begin
          result.next_pc = rv;
        end else if (br_opc == BR_OPC_BLR) begin
          result.next_pc = rv;
          link           = 1'b1;
        end else begin
          result.status = ST_UNIMPL;
        end
      end
      CL_SYS: begin
        result.status = ST_SYSTEM;
      end
      default: begin
        result.status = ST_UNIMPL;
      end
    endcase
    // The return address is reported only when X30 is written.
    result.link_write = link;
    result.link_value = link ? seq_pc : 64'd0;
  end

endmodule

/* src/aarch64_branch_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_branch_execute_unit
// Two-register branch execute pipeline: input register, decode, result register.
// ----------------------------------------------------------------------------
// Each item carries one instruction word with its pc, the NZCV flags and the
// named register value, and produces exactly one result: next pc, an optional
// link write of pc+4 to X30, and a status code. An accepted item is held in the
// input register, then its result in the result register under out_valid;
// throughput is one item per cycle while out_ready is not held low, set by the single
// decode and add pass between the input and result registers. in_ready drops
// only when both registers are full and out_ready is low.
module aarch64_branch_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [63:0] in_current_pc,
  input  logic [3:0]  in_flags_nzcv,
  input  logic [63:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_next_pc,
  output logic        out_link_write,
  output logic [63:0] out_link_value,
  output logic [2:0]  out_status
);
  import bru_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic [31:0]  insn_r;
  logic [63:0]  pc_r;
  logic [3:0]   nzcv_r;
  logic [63:0]  rv_r;
  logic         out_valid_r, out_valid_nxt;
  exec_result_t result_r;
  exec_result_t exec_res;
  logic         s2_ready;
  logic         s1_adv;
  logic         in_fire;

  // Handshake: each stage advances when the one after it has room.
  assign s2_ready = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & s2_ready;
  assign in_ready = ~s1_valid_r | s2_ready;
  assign in_fire  = in_valid & in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      insn_r <= in_instruction;
      pc_r   <= in_current_pc;
      nzcv_r <= in_flags_nzcv;
      rv_r   <= in_reg_value;
    end
  end

  bru_exec u_exec (
    .insn   (insn_r),
    .pc     (pc_r),
    .nzcv   (nzcv_r),
    .rv     (rv_r),
    .result (exec_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_r <= exec_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_pc    = result_r.next_pc;
  assign out_link_write = result_r.link_write;
  assign out_link_value = result_r.link_value;
  assign out_status     = result_r.status;

  // An item leaving the input register lands in the result register.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("item left input register but no result followed");

  // Backpressure only when both registers hold items.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free register");

  // No link value without a link write.
  a_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !result_r.link_write) |-> (result_r.link_value == 64'd0))
    else $error("link value set without link write");

  // Links come only from successful branches.
  a_link_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.link_write) |-> (result_r.status == ST_OK))
    else $error("link write with non-ok status");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AArch64 branch execute unit.
// ----------------------------------------------------------------------------
// A directed list of branch, exception, register-branch and system encodings
// is followed by random instructions built mostly from legal encodings of each
// class, with some raw words mixed in. Each accepted item is decoded by a
// local model, and every result is checked in order against it. Both channels
// idle in random bursts. The result side also holds off once for a long
// stretch, and the input side waits now and then for the unit to drain.
module tb_top;
  import bru_pkg::*;

  // Condition codes that need a name here; the never code comes from bru_pkg.
  typedef enum logic [3:0] {
    COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
    COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL
  } cond_code_t;

  // Encodings that have no name in the package.
  localparam logic [2:0] EXC_OPC_HLT  = 3'd2;
  localparam logic [3:0] BR_OPC_ERET  = 4'd4;
  localparam int         RANDOM_ITEMS = 1280;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         IDLE_TAIL    = 150;

  // One instruction item with its context.
  typedef struct {
    logic [31:0] insn;
    logic [63:0] pc;
    logic [3:0]  nzcv;
    logic [63:0] rv;
    logic        drain_first;
  } branch_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction = '0;
  logic [63:0] in_current_pc = '0;
  logic [3:0]  in_flags_nzcv = '0;
  logic [63:0] in_reg_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_next_pc;
  logic        out_link_write;
  logic [63:0] out_link_value;
  logic [2:0]  out_status;

  branch_item_t pending_insns[$];
  exec_result_t expected_results[$];
  branch_item_t insn_on_bus;
  int unsigned  n_total = 0;
  int unsigned  insns_accepted = 0;
  int unsigned  results_checked = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_hold = 0;
  int unsigned  quiet_cycles = 0;
  logic         long_hold_done = 1'b0;

  aarch64_branch_execute_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_instruction (in_instruction),
    .in_current_pc  (in_current_pc),
    .in_flags_nzcv  (in_flags_nzcv),
    .in_reg_value   (in_reg_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_pc    (out_next_pc),
    .out_link_write (out_link_write),
    .out_link_value (out_link_value),
    .out_status     (out_status)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Evaluates a condition code against the NZCV flags.
  function automatic logic cond_true(input logic [3:0] cond, input logic [3:0] nzcv);
    logic n, z, c, v, r;
    {n, z, c, v} = nzcv;
    case (cond)
      COND_EQ, COND_NE: r = z;
      COND_CS, COND_CC: r = c;
      COND_MI, COND_PL: r = n;
      COND_VS, COND_VC: r = v;
      COND_HI, COND_LS: r = c && !z;
      COND_GE, COND_LT: r = (n == v);
      COND_GT, COND_LE: r = (n == v) && !z;
      default:          r = 1'b1;
    endcase
    // Odd codes invert the test, except the never code, which is always too.
    if (cond[0] && cond != COND_NV) r = !r;
    return r;
  endfunction

  // Works out next pc, link write and status for one instruction.
  function automatic exec_result_t branch_outcome(input branch_item_t it);
    exec_result_t res;
    logic [31:0]  w;
    logic [63:0]  seq;
    logic [63:0]  tested;
    logic [5:0]   pos;
    logic         taken;
    w = it.insn;
    seq = it.pc + 64'd4;
    res.next_pc = it.pc;
    res.link_write = 1'b0;
    res.link_value = '0;
    res.status = ST_OK;
    if ((w & MASK_B) == MATCH_B) begin
      res.next_pc = it.pc + {{36{w[25]}}, w[25:0], 2'b00};
      res.link_write = w[31];
    end else if ((w & MASK_BCOND) == MATCH_BCOND) begin
      taken = cond_true(w[3:0], it.nzcv);
      res.next_pc = taken ? it.pc + {{43{w[23]}}, w[23:5], 2'b00} : seq;
    end else if ((w & MASK_CTBR) == MATCH_CMPBR) begin
      // The 32-bit form only looks at the low word.
      tested = w[31] ? it.rv : {32'h0, it.rv[31:0]};
      taken = ((tested != 64'd0) == w[24]);
      res.next_pc = taken ? it.pc + {{43{w[23]}}, w[23:5], 2'b00} : seq;
    end else if ((w & MASK_CTBR) == MATCH_TSTBR) begin
      pos = {w[31], w[23:19]};
      taken = (it.rv[pos] == w[24]);
      res.next_pc = taken ? it.pc + {{48{w[18]}}, w[18:5], 2'b00} : seq;
    end else if ((w & MASK_EXC) == MATCH_EXC) begin
      if (w[23:21] == EXC_OPC_SVC && w[1:0] == EXC_LL_SVC) begin
        res.next_pc = seq;
        res.status = ST_SVC;
      end else if (w[23:21] == EXC_OPC_BRK && w[1:0] == EXC_LL_BRK) begin
        res.status = ST_BRK;
      end else begin
        res.status = ST_UNIMPL;
      end
    end else if ((w & MASK_BRREG) == MATCH_BRREG) begin
      case (w[24:21])
        BR_OPC_BR, BR_OPC_RET: res.next_pc = it.rv;
        BR_OPC_BLR: begin
          res.next_pc = it.rv;
          res.link_write = 1'b1;
        end
        default: res.status = ST_UNIMPL;
      endcase
    end else if ((w & MASK_SYS) == MATCH_SYS) begin
      res.status = ST_SYSTEM;
    end else begin
      res.status = ST_UNIMPL;
    end
    if (res.link_write) res.link_value = seq;
    return res;
  endfunction

  // Appends one instruction to the stimulus list.
  task automatic add_insn(input logic [31:0] insn, input logic [63:0] pc,
                          input logic [3:0] nzcv, input logic [63:0] rv,
                          input logic drain_first);
    branch_item_t it;
    it.insn = insn;
    it.pc = pc;
    it.nzcv = nzcv;
    it.rv = rv;
    it.drain_first = drain_first;
    pending_insns.push_back(it);
    n_total++;
  endtask

  // Builds the stimulus, releases reset and decides the outcome.
  initial begin
    logic [31:0] r;
    logic [31:0] w;
    logic [63:0] pc;
    logic [63:0] rv;
    logic [3:0]  opc;

    // Directed part: offsets at their extremes, wrap-around, each class.
    add_insn(MATCH_B | 32'h01FF_FFFF, 64'h1000, 4'h0, 64'h0, 1'b0);
    add_insn(MATCH_B | 32'h8200_0000, 64'h100, 4'h0, 64'h0, 1'b0);
    add_insn(MATCH_B | 32'h0000_0010, 64'hFFFF_FFFF_FFFF_FFF0, 4'h0, 64'h0, 1'b0);
    add_insn(MATCH_BCOND | {8'h0, 19'h00010, 1'b0, COND_EQ}, 64'h2000, 4'b0100, 64'h0, 1'b0);
    add_insn(MATCH_BCOND | {8'h0, 19'h00010, 1'b0, COND_LT}, 64'h2000, 4'b1000, 64'h0, 1'b0);
    add_insn(MATCH_BCOND | {8'h0, 19'h00010, 1'b0, COND_GT}, 64'h2000, 4'b0100, 64'h0, 1'b0);
    add_insn(MATCH_BCOND | {8'h0, 19'h40000, 1'b0, COND_AL}, 64'h3000, 4'h0, 64'h0, 1'b0);
    add_insn(MATCH_BCOND | {8'h0, 19'h3FFFF, 1'b0, COND_NV}, 64'h3000, 4'hF, 64'h0, 1'b0);
    add_insn(MATCH_CMPBR | {1'b0, 6'h0, 1'b0, 19'h00004, 5'd1}, 64'h4000, 4'h0,
             64'hFFFF_FFFF_0000_0000, 1'b0);
    add_insn(MATCH_CMPBR | {1'b1, 6'h0, 1'b1, 19'h3FFFF, 5'd2}, 64'h4000, 4'h0,
             64'hFFFF_FFFF_0000_0000, 1'b0);
    add_insn(MATCH_CMPBR | {1'b0, 6'h0, 1'b1, 19'h00004, 5'd3}, 64'h4000, 4'h0,
             64'hFFFF_FFFF_0000_0000, 1'b0);
    add_insn(MATCH_TSTBR | {1'b1, 6'h0, 1'b0, 5'h1F, 14'h0008, 5'd4}, 64'h5000, 4'h0,
             64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_insn(MATCH_TSTBR | {1'b0, 6'h0, 1'b1, 5'h00, 14'h2000, 5'd5}, 64'h5000, 4'h0,
             64'h1, 1'b0);
    add_insn(MATCH_EXC | {8'h0, EXC_OPC_SVC, 16'hFFFF, 3'b000, EXC_LL_SVC}, 64'h6000, 4'h0,
             64'h0, 1'b0);
    add_insn(MATCH_EXC | {8'h0, EXC_OPC_BRK, 16'h0000, 3'b111, EXC_LL_BRK}, 64'h6004, 4'h0,
             64'h0, 1'b0);
    add_insn(MATCH_EXC | {8'h0, EXC_OPC_HLT, 16'h1234, 3'b000, 2'b00}, 64'h6008, 4'h0,
             64'h0, 1'b0);
    add_insn(MATCH_BRREG | {7'h0, BR_OPC_BR, 21'h0000E0}, 64'h7000, 4'h0,
             64'h0123_4567_89AB_CDEF, 1'b0);
    add_insn(MATCH_BRREG | {7'h0, BR_OPC_BLR, 21'h000020}, 64'hFFFF_FFFF_FFFF_FFFC, 4'h0,
             64'h8000, 1'b0);
    add_insn(MATCH_BRREG | {7'h0, BR_OPC_RET, 21'h0003C0}, 64'h7008, 4'h0,
             64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_insn(MATCH_BRREG | {7'h0, BR_OPC_ERET, 21'h1FFFFF}, 64'h700C, 4'h0, 64'h0, 1'b0);
    add_insn(MATCH_SYS | 32'h0003_201F, 64'h7010, 4'h0, 64'h0, 1'b0);
    add_insn(32'h0000_0000, 64'h7014, 4'h0, 64'h0, 1'b0);
    add_insn(32'hFFFF_FFFF, 64'h7018, 4'h0, 64'h0, 1'b0);

    // Random part: mostly legal encodings of each class with random fields.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom;
      rv = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       pc = {32'h0, 24'h0, r[7:0]};
        1:       pc = {56'hFF_FFFF_FFFF_FFFF, r[15:8]};
        default: pc = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: w = MATCH_B | {r[31], 5'h0, r[25:0]};
        3, 4, 5, 6: w = MATCH_BCOND | {8'h0, r[23:5], 1'b0, r[3:0]};
        7, 8, 9: begin
          w = MATCH_CMPBR | {r[31], 6'h0, r[24:0]};
          case ($urandom_range(0, 3))
            0: rv = 64'h0;
            1: rv[31:0] = 32'h0;
            2: rv[63:32] = 32'h0;
            default: ;
          endcase
        end
        10, 11, 12: begin
          w = MATCH_TSTBR | {r[31], 6'h0, r[24:0]};
          if ($urandom_range(0, 1)) rv[{w[31], w[23:19]}] = w[24];
        end
        13, 14: begin
          case ($urandom_range(0, 2))
            0: w = MATCH_EXC | {8'h0, EXC_OPC_SVC, r[20:2], EXC_LL_SVC};
            1: w = MATCH_EXC | {8'h0, EXC_OPC_BRK, r[20:2], EXC_LL_BRK};
            default: w = MATCH_EXC | {8'h0, r[23:0]};
          endcase
        end
        15, 16: begin
          opc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 2));
          w = MATCH_BRREG | {7'h0, opc, r[20:0]};
        end
        17: w = MATCH_SYS | {10'h0, r[21:0]};
        default: w = r;
      endcase
      add_insn(w, pc, 4'($urandom_range(0, 15)), rv, (i % 300) == 0);
    end

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to come back.
    wait (insns_accepted == n_total);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: offers items from the pending list, with random idle bursts.
  always @(posedge clk) begin
    logic offer;
    logic idle_ok;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(branch_outcome(insn_on_bus));
        insns_accepted++;
        offer = 1'b0;
      end
      idle_ok = (pending_insns.size() > IDLE_TAIL) && ((insns_accepted / 120) % 4 != 3);
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_insns.size() != 0 &&
                     !(pending_insns[0].drain_first && expected_results.size() != 0)) begin
          if (idle_ok && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
          end else begin
            insn_on_bus = pending_insns.pop_front();
            in_instruction <= insn_on_bus.insn;
            in_current_pc <= insn_on_bus.pc;
            in_flags_nzcv <= insn_on_bus.nzcv;
            in_reg_value <= insn_on_bus.rv;
            offer = 1'b1;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // Result side ready: random bursts plus one long hold-off.
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (recv_hold > 0) begin
        recv_hold--;
        rdy = 1'b0;
      end else if (!long_hold_done && results_checked >= 500) begin
        long_hold_done = 1'b1;
        recv_hold = 149;
        rdy = 1'b0;
      end else if ((insns_accepted + IDLE_TAIL < n_total) &&
                   ((results_checked / 120) % 4 != 3) && $urandom_range(0, 5) == 0) begin
        recv_hold = $urandom_range(1, 19) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    exec_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_next_pc !== exp_res.next_pc) begin
          $error("next_pc: expected %h, got %h", exp_res.next_pc, out_next_pc);
          mismatches++;
        end
        if (out_link_write !== exp_res.link_write) begin
          $error("link_write: expected %b, got %b", exp_res.link_write, out_link_write);
          mismatches++;
        end
        if (out_link_value !== exp_res.link_value) begin
          $error("link_value: expected %h, got %h", exp_res.link_value, out_link_value);
          mismatches++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
